[rtl/core/bol_pkg.sv]
// ----------------------------------------------------------------------------
// bol_pkg
// Shared types and codes for the bounded ordered list: request and result
// beats, operation and status codes, cell control and controller states.
// ----------------------------------------------------------------------------
package bol_pkg;

    // Width of a cell position; covers the largest supported capacity (256)
    localparam int POS_W = 8;

    typedef enum logic [3:0] {
        OP_PUSH_FRONT   = 4'd0,
        OP_APPEND       = 4'd1,
        OP_POP_FRONT    = 4'd2,
        OP_INSERT_AT    = 4'd3,
        OP_DELETE_AT    = 4'd4,
        OP_DELETE_VALUE = 4'd5,
        OP_READ_AT      = 4'd6,
        OP_CONTAINS     = 4'd7,
        OP_CLEAR        = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_MISS  = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_DONE = 2'd2
    } state_t;

    // What every cell of the chain does in the execute cycle
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_INS   = 2'd1,
        CELL_DEL   = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [POS_W-1:0] pos;
    } bol_ctrl_t;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] value;
        logic [4:0]  index;
        logic [31:0] fallback_value;
    } bol_req_t;

    typedef struct packed {
        logic [31:0] result_value;
        logic [1:0]  status;
        logic        found;
        logic [4:0]  length;
        logic [31:0] front_value;
        logic [31:0] rear_value;
    } bol_rsp_t;

endpackage

[rtl/core/bol_cell.sv]
// ----------------------------------------------------------------------------
// bol_cell
// One position of the list. Holds one word and, on command, takes the word
// of its left neighbor (open a gap), of its right neighbor (close a gap) or
// the new word.
// ----------------------------------------------------------------------------
module bol_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  bol_pkg::bol_ctrl_t    ctrl,
    input  logic [DATA_WIDTH-1:0] ins_data,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    output logic [DATA_WIDTH-1:0] data
);

    localparam logic [bol_pkg::POS_W-1:0] MY_POS = IDX[bol_pkg::POS_W-1:0];

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // Pick the word this cell holds after the execute cycle
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            bol_pkg::CELL_INS:
            begin
                if (MY_POS > ctrl.pos)
                begin
                    data_next = left_data;
                end
                else if (MY_POS == ctrl.pos)
                begin
                    data_next = ins_data;
                end
            end
            bol_pkg::CELL_DEL:
            begin
                if (MY_POS >= ctrl.pos)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Hold the word
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/core/bounded_ordered_list.sv]
// A request accepted at one edge executes in the next cycle; its result
//   strobes on done in the cycle after that.
// A new request is taken in the cycle its predecessor's result is shown, but
//   not while the cell row is executing (busy).
// Reset clears the entry count and the controller; stored words are not cleared.
// There is no backpressure on results: each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// bounded_ordered_list
// Ordered list of up to CAPACITY words held in a row of cells. Inserts and
// deletes shift the row by one position; searches compare every cell at once.
// ----------------------------------------------------------------------------
module bounded_ordered_list #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  bol_pkg::bol_req_t req,
    output logic              done,
    output bol_pkg::bol_rsp_t rsp
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam int PW   = bol_pkg::POS_W;

    bol_pkg::state_t       state_reg;
    bol_pkg::state_t       state_next;
    bol_pkg::bol_req_t     req_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [31:0]           res_value_reg;
    logic [31:0]           res_value_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic                  found_reg;
    logic                  found_next;
    logic [31:0]           fb_reg;

    logic                  accept;
    logic                  exec;
    bol_pkg::bol_ctrl_t    ctrl;
    bol_pkg::cell_op_t     cell_op;
    logic [PW-1:0]         cell_pos;
    logic [PW-1:0]         sel_pos;
    logic [PW-1:0]         rear_pos;
    logic [PW-1:0]         hit_pos;
    logic                  hit;
    logic [DATA_WIDTH-1:0] ins_data;
    logic [DATA_WIDTH-1:0] sel_data;
    logic [DATA_WIDTH-1:0] rear_data;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]   match;
    logic [CMPW-1:0]       idx_c;
    logic [CMPW-1:0]       cnt_c;
    logic                  full;

    // Controller: idle, execute, show result
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bol_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = bol_pkg::S_EXEC;
                end
            end
            bol_pkg::S_EXEC:
            begin
                state_next = bol_pkg::S_DONE;
            end
            bol_pkg::S_DONE:
            begin
                state_next = start ? bol_pkg::S_EXEC : bol_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bol_pkg::S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg == bol_pkg::S_EXEC);
    assign done   = (state_reg == bol_pkg::S_DONE);
    assign exec   = busy;
    assign accept = start && !busy;

    // Size the request word to the stored data width
    assign ins_data = DATA_WIDTH'({32'b0, req_reg.value});
    assign idx_c    = CMPW'(req_reg.index);
    assign cnt_c    = CMPW'(count_reg);
    assign full     = (count_reg == CW'(CAPACITY));

    // Decode the request into a cell command and the result fields
    always_comb
    begin
        cell_op        = bol_pkg::CELL_HOLD;
        cell_pos       = '0;
        sel_pos        = '0;
        count_next     = count_reg;
        res_value_next = req_reg.fallback_value;
        status_next    = bol_pkg::STAT_OK;
        found_next     = 1'b0;
        case (req_reg.op)
            bol_pkg::OP_PUSH_FRONT,
            bol_pkg::OP_APPEND:
            begin
                if (full)
                begin
                    status_next = bol_pkg::STAT_FULL;
                end
                else
                begin
                    cell_op    = bol_pkg::CELL_INS;
                    cell_pos   = (req_reg.op == bol_pkg::OP_APPEND) ? PW'(count_reg) : '0;
                    count_next = count_reg + 1'b1;
                end
            end
            bol_pkg::OP_POP_FRONT:
            begin
                if (count_reg == '0)
                begin
                    status_next = bol_pkg::STAT_MISS;
                end
                else
                begin
                    cell_op        = bol_pkg::CELL_DEL;
                    count_next     = count_reg - 1'b1;
                    res_value_next = 32'(64'(sel_data));
                end
            end
            bol_pkg::OP_INSERT_AT:
            begin
                if (idx_c > cnt_c)
                begin
                    status_next = bol_pkg::STAT_RANGE;
                end
                else if (full)
                begin
                    status_next = bol_pkg::STAT_FULL;
                end
                else
                begin
                    cell_op    = bol_pkg::CELL_INS;
                    cell_pos   = PW'(req_reg.index);
                    count_next = count_reg + 1'b1;
                end
            end
            bol_pkg::OP_DELETE_AT,
            bol_pkg::OP_READ_AT:
            begin
                sel_pos = PW'(req_reg.index);
                if (idx_c > cnt_c)
                begin
                    status_next = bol_pkg::STAT_RANGE;
                end
                else if (idx_c == cnt_c)
                begin
                    status_next = bol_pkg::STAT_MISS;
                end
                else
                begin
                    res_value_next = 32'(64'(sel_data));
                    if (req_reg.op == bol_pkg::OP_DELETE_AT)
                    begin
                        cell_op    = bol_pkg::CELL_DEL;
                        cell_pos   = PW'(req_reg.index);
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            bol_pkg::OP_DELETE_VALUE,
            bol_pkg::OP_CONTAINS:
            begin
                if (!hit)
                begin
                    status_next = bol_pkg::STAT_MISS;
                end
                else if (req_reg.op == bol_pkg::OP_DELETE_VALUE)
                begin
                    // the removed entry equals the masked search word
                    res_value_next = 32'(64'(ins_data));
                    cell_op        = bol_pkg::CELL_DEL;
                    cell_pos       = hit_pos;
                    count_next     = count_reg - 1'b1;
                end
                else
                begin
                    found_next = 1'b1;
                end
            end
            bol_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status_next = bol_pkg::STAT_OK;
            end
        endcase
    end

    assign ctrl.op  = exec ? cell_op : bol_pkg::CELL_HOLD;
    assign ctrl.pos = cell_pos;

    // Row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = ins_data;
        end
        else
        begin : g_left
            assign left_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = cell_data[i];
        end
        else
        begin : g_right
            assign right_w = cell_data[i+1];
        end

        bol_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .ins_data   (ins_data),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i])
        );

        // Compare this cell against the search word, valid entries only
        assign match[i] = (cell_data[i] == ins_data) && (CW'(i) < count_reg);
    end

    // Find the first matching position
    always_comb
    begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int k = CAPACITY - 1; k >= 0; k--)
        begin
            if (match[k])
            begin
                hit     = 1'b1;
                hit_pos = PW'(k);
            end
        end
    end

    // Select the word at the read position and at the rear
    assign rear_pos = PW'(count_reg - 1'b1);

    always_comb
    begin
        sel_data  = '0;
        rear_data = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (PW'(k) == sel_pos)
            begin
                sel_data = sel_data | cell_data[k];
            end
            if (PW'(k) == rear_pos)
            begin
                rear_data = rear_data | cell_data[k];
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bol_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Capture the request beat and the result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (exec)
        begin
            res_value_reg <= res_value_next;
            status_reg    <= status_next;
            found_reg     <= found_next;
            fb_reg        <= req_reg.fallback_value;
        end
    end

    // Drive the result beat
    assign rsp.result_value = res_value_reg;
    assign rsp.status       = status_reg;
    assign rsp.found        = found_reg;
    assign rsp.length       = cnt_c[4:0];
    assign rsp.front_value  = (count_reg != '0) ? 32'(64'(cell_data[0])) : fb_reg;
    assign rsp.rear_value   = (count_reg != '0) ? 32'(64'(rear_data)) : fb_reg;

endmodule

[rtl/core/bol_checker.sv]
// ----------------------------------------------------------------------------
// bol_checker
// Port-level checks on the bounded ordered list: request/result timing and
// consistency of the result beat.
// ----------------------------------------------------------------------------
module bol_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input bol_pkg::bol_rsp_t rsp
);

    // An accepted beat executes in the next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not enter execute");

    // Execute is always followed by a result beat
    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("execute not followed by result");

    // A result never shows without a request executed the cycle before
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without request");

    // A found flag implies success
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.found |-> rsp.status == bol_pkg::STAT_OK)
        else $error("found set with failing status");

    // An empty list reports the same word at front and rear
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.length == 5'd0 |-> rsp.front_value == rsp.rear_value)
        else $error("empty list front and rear differ");

endmodule

bind bounded_ordered_list bol_checker u_bol_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
